// File: sv/thop_pkg.sv
// shared types and constants for the tcp header option parser
package thop_pkg;

	localparam int unsigned MIN_HDR_BYTES = 20;
	localparam int unsigned OFFSET_BYTE   = 12;
	localparam int unsigned MIN_DOFF      = 5;

	// option kinds on the wire
	localparam logic [7:0] KIND_END  = 8'd0;
	localparam logic [7:0] KIND_NOP  = 8'd1;
	localparam logic [7:0] KIND_MSS  = 8'd2;
	localparam logic [7:0] KIND_WS   = 8'd3;
	localparam logic [7:0] KIND_SACK = 8'd4;
	localparam logic [7:0] KIND_TS   = 8'd8;

	// required option length bytes
	localparam logic [7:0] LEN_MSS  = 8'd4;
	localparam logic [7:0] LEN_WS   = 8'd3;
	localparam logic [7:0] LEN_SACK = 8'd2;
	localparam logic [7:0] LEN_TS   = 8'd10;

	// value and skip byte counts after the length byte
	localparam logic [3:0] VAL_MSS  = 4'd2;
	localparam logic [3:0] VAL_WS   = 4'd1;
	localparam logic [3:0] SKIP_TS  = 4'd8;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_HDR     = 3'd2,
		ST_BADLEN  = 3'd3,
		ST_OVERRUN = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_KIND  = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_SKIP  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		PK_MSS  = 2'd0,
		PK_WS   = 2'd1,
		PK_SACK = 2'd2,
		PK_TS   = 2'd3
	} pkind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} beat_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  hdr_len;
		logic [15:0] mss;
		logic        mss_present;
		logic [7:0]  wscale;
		logic        wscale_present;
		logic        sack_permitted;
		logic [5:0]  nop_count;
		logic [5:0]  pad_len;
	} result_t;

endpackage

// File: sv/thop_parse.sv
// per-segment parse state and option decode for one byte
module thop_parse import thop_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  beat_t   beat,
	output result_t result
);

	logic [15:0] pos_q, pos_n;
	logic [3:0]  hw_q, hw_n;
	pkind_t      kind_q, kind_n;
	phase_t      phase_q, phase_n;
	logic [3:0]  btc_q, btc_n;
	logic [15:0] mss_q, mss_n;
	logic [7:0]  scale_q, scale_n;
	logic [2:0]  present_q, present_n;
	logic [5:0]  nop_q, nop_n;
	logic [5:0]  endoff_q, endoff_n;
	logic        endseen_q, endseen_n;
	status_t     err_q, err_n, err_fin;
	logic [5:0]  ps;
	logic        active;
	logic [7:0]  b;
	logic [7:0]  want;
	status_t     st;

	assign b  = beat.data_byte;
	assign hw_n = (pos_q == 16'(OFFSET_BYTE)) ? b[7:4] : hw_q;
	assign ps = {hw_n, 2'b00};
	assign active = (hw_n >= 4'(MIN_DOFF)) && (err_q == ST_OK) && !endseen_q;

	always_comb begin
		case (kind_q)
			PK_MSS:  want = LEN_MSS;
			PK_WS:   want = LEN_WS;
			PK_SACK: want = LEN_SACK;
			default: want = LEN_TS;
		endcase
	end

	always_comb begin
		kind_n    = kind_q;
		phase_n   = phase_q;
		btc_n     = btc_q;
		mss_n     = mss_q;
		scale_n   = scale_q;
		present_n = present_q;
		nop_n     = nop_q;
		endoff_n  = endoff_q;
		endseen_n = endseen_q;
		err_n     = err_q;
		if (pos_q >= 16'(MIN_HDR_BYTES) && active) begin
			if (pos_q < {10'd0, ps}) begin
				case (phase_q)
					PH_KIND: begin
						if (b == KIND_END) begin
							endseen_n = 1'b1;
							endoff_n  = pos_q[5:0] + 6'd1;
						end else if (b == KIND_NOP) begin
							nop_n = nop_q + 6'd1;
						end else if (b == KIND_MSS) begin
							kind_n  = PK_MSS;
							phase_n = PH_LEN;
						end else if (b == KIND_WS) begin
							kind_n  = PK_WS;
							phase_n = PH_LEN;
						end else if (b == KIND_SACK) begin
							kind_n  = PK_SACK;
							phase_n = PH_LEN;
						end else if (b == KIND_TS) begin
							kind_n  = PK_TS;
							phase_n = PH_LEN;
						end
					end
					PH_LEN: begin
						if (b != want) begin
							err_n = ST_BADLEN;
						end else begin
							case (kind_q)
								PK_MSS: begin
									phase_n = PH_VALUE;
									btc_n   = VAL_MSS;
								end
								PK_WS: begin
									phase_n = PH_VALUE;
									btc_n   = VAL_WS;
								end
								PK_SACK: begin
									present_n[2] = 1'b1;
									phase_n      = PH_KIND;
								end
								default: begin
									phase_n = PH_SKIP;
									btc_n   = SKIP_TS;
								end
							endcase
						end
					end
					PH_VALUE: begin
						if (kind_q == PK_MSS) begin
							mss_n = {mss_q[7:0], b};
							btc_n = btc_q - 4'd1;
							if (btc_q == 4'd1) begin
								present_n[0] = 1'b1;
								phase_n      = PH_KIND;
							end
						end else begin
							scale_n      = b;
							present_n[1] = 1'b1;
							phase_n      = PH_KIND;
							btc_n        = 4'd0;
						end
					end
					PH_SKIP: begin
						btc_n = btc_q - 4'd1;
						if (btc_q == 4'd1) begin
							phase_n = PH_KIND;
						end
					end
					default: begin
						phase_n = PH_KIND;
					end
				endcase
			end else if (phase_q != PH_KIND) begin
				err_n = ST_OVERRUN;
			end
		end
	end

	assign pos_n = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;

	// final status; an option open at segment end is an overrun
	always_comb begin
		err_fin = err_n;
		if (hw_n >= 4'(MIN_DOFF) && err_n == ST_OK && !endseen_n && phase_n != PH_KIND) begin
			err_fin = ST_OVERRUN;
		end
		if (pos_n < 16'(MIN_HDR_BYTES)) begin
			st = ST_SHORT;
		end else if (hw_n < 4'(MIN_DOFF) || {10'd0, ps} > pos_n) begin
			st = ST_HDR;
		end else begin
			st = err_fin;
		end
	end

	always_comb begin
		result = '0;
		result.status = st;
		if (st == ST_OK) begin
			result.hdr_len        = ps;
			result.mss            = mss_n;
			result.mss_present    = present_n[0];
			result.wscale         = scale_n;
			result.wscale_present = present_n[1];
			result.sack_permitted = present_n[2];
			result.nop_count      = nop_n;
			result.pad_len        = (endseen_n && ps >= endoff_n) ? ps - endoff_n : 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hw_q      <= '0;
			kind_q    <= PK_MSS;
			phase_q   <= PH_KIND;
			btc_q     <= '0;
			mss_q     <= '0;
			scale_q   <= '0;
			present_q <= '0;
			nop_q     <= '0;
			endoff_q  <= '0;
			endseen_q <= 1'b0;
			err_q     <= ST_OK;
		end else if (step) begin
			if (beat.last) begin
				pos_q     <= '0;
				hw_q      <= '0;
				kind_q    <= PK_MSS;
				phase_q   <= PH_KIND;
				btc_q     <= '0;
				mss_q     <= '0;
				scale_q   <= '0;
				present_q <= '0;
				nop_q     <= '0;
				endoff_q  <= '0;
				endseen_q <= 1'b0;
				err_q     <= ST_OK;
			end else begin
				pos_q     <= pos_n;
				hw_q      <= hw_n;
				kind_q    <= kind_n;
				phase_q   <= phase_n;
				btc_q     <= btc_n;
				mss_q     <= mss_n;
				scale_q   <= scale_n;
				present_q <= present_n;
				nop_q     <= nop_n;
				endoff_q  <= endoff_n;
				endseen_q <= endseen_n;
				err_q     <= err_n;
			end
		end
	end

endmodule

// File: sv/thop_outq.sv
// result register on the output side
module thop_outq import thop_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t din,
	input  logic    take,
	output logic    valid,
	output result_t dout,
	output logic    free
);

	logic    valid_s2;
	result_t res_s2;

	assign free  = !valid_s2 || take;
	assign valid = valid_s2;
	assign dout  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= din;
		end
	end

endmodule

// File: sv/tcp_header_option_parser.sv
// top level of the tcp header option parser
// usage:
//   a tcp segment enters on the s_ channel one byte per beat, in wire order,
//   with s_tlast on its final byte. the data offset is taken from byte 12
//   and options are decoded from byte 20 up to the payload start.
//   on the last byte one summary beat leaves on the m_ channel: status,
//   payload start, mss, window scale, sack-permitted, nop count, padding.
//   bytes other than the last produce no output beat.
// timing:
//   a byte is registered on acceptance and decoded from the input register
//   against the per-segment state; the summary lands in the output register,
//   and m_tvalid rises once the last byte's summary is loaded there.
//   one byte per cycle sustained while the output register can take each
//   last byte; back-to-back segments need no gap.
// reset:
//   arst_n clears the parse state and both valid flags; the next byte after
//   reset, or after any last byte, starts a new segment.
// stall:
//   while m_tready is low the summary holds; middle bytes keep flowing,
//   only a following last byte waits in the input register, and s_tready
//   drops until the output register frees up.
module tcp_header_option_parser import thop_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last byte of the segment
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] status, [8:3] hdr_len, [24:9] mss, [25] mss_present,
	// [33:26] wscale, [34] wscale_present, [35] sack_permitted,
	// [41:36] nop_count, [47:42] pad_len
	output logic [47:0] m_tdata
);

	logic    valid_s1;
	beat_t   beat_s1;
	logic    advance;
	logic    out_free;
	result_t res_comb;
	result_t res_out;

	// a middle byte always moves on; a last byte needs room in the output register
	assign advance  = valid_s1 && (!beat_s1.last || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.data_byte <= s_tdata;
			beat_s1.last      <= s_tlast;
		end
	end

	thop_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.result (res_comb)
	);

	thop_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && beat_s1.last),
		.din    (res_comb),
		.take   (m_tready),
		.valid  (m_tvalid),
		.dout   (res_out),
		.free   (out_free)
	);

	// pack the summary beat, first field lowest
	assign m_tdata = {
		res_out.pad_len,
		res_out.nop_count,
		res_out.sack_permitted,
		res_out.wscale_present,
		res_out.wscale,
		res_out.mss_present,
		res_out.mss,
		res_out.hdr_len,
		res_out.status
	};

endmodule

// File: test/tcp_header_option_parser_tb.sv
// testbench for the tcp header option parser: segments in byte by byte, summary beats checked
`timescale 1ns / 1ps

module tcp_header_option_parser_tb;
	import thop_pkg::*;

	localparam int unsigned STALL_LIMIT     = 1000; // cycles with no beat on either side
	localparam int unsigned SETTLE_CYCLES   = 6;
	localparam int unsigned RANDOM_BYTES    = 700;
	localparam int unsigned RANDOM_SEGMENTS = 16;
	localparam int unsigned LONG_SEGMENT    = 300;  // long payload sent without gaps

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0; // [7:0] data_byte
	logic        s_tlast  = 1'b0; // last byte of the segment
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [2:0] status, [8:3] hdr_len, [24:9] mss, [25] mss_present,
	// [33:26] wscale, [34] wscale_present, [35] sack_permitted,
	// [41:36] nop_count, [47:42] pad_len
	logic [47:0] m_tdata;

	// per-segment parse state mirrored on the testbench side
	logic [15:0] seg_count  = '0; // bytes seen, saturating
	logic [3:0]  seg_doff   = '0;
	logic [7:0]  open_kind  = '0;
	phase_t      opt_phase  = PH_KIND;
	logic [3:0]  opt_left   = '0;
	logic [15:0] mss_val    = '0;
	logic [7:0]  ws_val     = '0;
	logic        has_mss    = 1'b0;
	logic        has_ws     = 1'b0;
	logic        has_sack   = 1'b0;
	logic [5:0]  nop_total  = '0;
	logic [5:0]  end_index  = '0; // byte index just after END
	logic        end_hit    = 1'b0;
	status_t     opt_error  = ST_OK;

	result_t     expected_summaries[$];
	logic [7:0]  seg_bytes[$];      // segment being built
	bit          sender_gaps     = 1'b1;
	bit          receiver_stalls = 1'b1;
	int unsigned errors      = 0;
	int unsigned idle_cycles = 0;

	tcp_header_option_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the segment parse by one accepted byte; on the last byte
	// queue the summary the block owes and start over
	task automatic predict_byte(input logic [7:0] value, input logic final_byte);
		logic [15:0] at;
		logic [5:0]  hdr_bytes;
		logic [7:0]  need;
		bit          live;
		result_t     sum;
		at = seg_count;
		if (at == OFFSET_BYTE)
			seg_doff = value[7:4];
		hdr_bytes = {seg_doff, 2'b00};
		live = seg_doff >= MIN_DOFF && opt_error == ST_OK && !end_hit;
		if (at >= MIN_HDR_BYTES && live) begin
			if (at < hdr_bytes) begin
				case (opt_phase)
					PH_KIND: begin
						if (value == KIND_END) begin
							end_hit   = 1'b1;
							end_index = at[5:0] + 6'd1;
						end else if (value == KIND_NOP) begin
							nop_total = nop_total + 6'd1;
						end else if (value == KIND_MSS || value == KIND_WS ||
								value == KIND_SACK || value == KIND_TS) begin
							open_kind = value;
							opt_phase = PH_LEN;
						end
						// any other kind is a single byte and is passed over
					end
					PH_LEN: begin
						case (open_kind)
							KIND_MSS:  need = LEN_MSS;
							KIND_WS:   need = LEN_WS;
							KIND_SACK: need = LEN_SACK;
							default:   need = LEN_TS;
						endcase
						if (value != need) begin
							opt_error = ST_BADLEN;
						end else begin
							case (open_kind)
								KIND_MSS: begin
									opt_phase = PH_VALUE;
									opt_left  = VAL_MSS;
								end
								KIND_WS: begin
									opt_phase = PH_VALUE;
									opt_left  = VAL_WS;
								end
								KIND_SACK: begin
									has_sack  = 1'b1;
									opt_phase = PH_KIND;
									open_kind = KIND_END;
								end
								default: begin
									opt_phase = PH_SKIP;
									opt_left  = SKIP_TS;
								end
							endcase
						end
					end
					PH_VALUE: begin
						if (open_kind == KIND_MSS) begin
							// big-endian, shifted in a byte at a time
							mss_val  = {mss_val[7:0], value};
							opt_left = opt_left - 4'd1;
							if (opt_left == 4'd0) begin
								has_mss   = 1'b1;
								opt_phase = PH_KIND;
								open_kind = KIND_END;
							end
						end else begin
							ws_val    = value;
							has_ws    = 1'b1;
							opt_phase = PH_KIND;
							open_kind = KIND_END;
							opt_left  = 4'd0;
						end
					end
					default: begin
						// timestamp body is skipped
						opt_left = opt_left - 4'd1;
						if (opt_left == 4'd0) begin
							opt_phase = PH_KIND;
							open_kind = KIND_END;
						end
					end
				endcase
			end else if (opt_phase != PH_KIND) begin
				// an option still open when the payload starts
				opt_error = ST_OVERRUN;
			end
		end
		if (seg_count != 16'hFFFF)
			seg_count = seg_count + 16'd1;
		if (final_byte) begin
			if (seg_doff >= MIN_DOFF && opt_error == ST_OK && !end_hit && opt_phase != PH_KIND)
				opt_error = ST_OVERRUN;
			sum = '0;
			if (seg_count < MIN_HDR_BYTES)
				sum.status = ST_SHORT;
			else if (seg_doff < MIN_DOFF || hdr_bytes > seg_count)
				sum.status = ST_HDR;
			else
				sum.status = opt_error;
			// every other field stays zero on an error
			if (sum.status == ST_OK) begin
				sum.hdr_len        = hdr_bytes;
				sum.mss            = mss_val;
				sum.mss_present    = has_mss;
				sum.wscale         = ws_val;
				sum.wscale_present = has_ws;
				sum.sack_permitted = has_sack;
				sum.nop_count      = nop_total;
				sum.pad_len        = (end_hit && hdr_bytes >= end_index) ?
					hdr_bytes - end_index : 6'd0;
			end
			expected_summaries.push_back(sum);
			seg_count = '0;
			seg_doff  = '0;
			open_kind = '0;
			opt_phase = PH_KIND;
			opt_left  = '0;
			mss_val   = '0;
			ws_val    = '0;
			has_mss   = 1'b0;
			has_ws    = 1'b0;
			has_sack  = 1'b0;
			nop_total = '0;
			end_index = '0;
			end_hit   = 1'b0;
			opt_error = ST_OK;
		end
	endtask

	// one byte beat on the slave side, after a random gap when gaps are on
	task automatic send_byte(input logic [7:0] value, input logic final_byte);
		int unsigned gap;
		gap = sender_gaps ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= final_byte;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_byte(value, final_byte);
	endtask

	task automatic send_segment();
		for (int i = 0; i < seg_bytes.size(); i++)
			send_byte(seg_bytes[i], i == seg_bytes.size() - 1);
	endtask

	// sender goes quiet until every summary is back, then lets the pipe settle
	task automatic wait_for_summaries();
		s_tvalid <= 1'b0;
		while (expected_summaries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// fixed 20-byte header with random contents and the given data offset
	task automatic begin_segment(input logic [3:0] doff);
		seg_bytes.delete();
		for (int i = 0; i < MIN_HDR_BYTES; i++)
			seg_bytes.push_back(i == OFFSET_BYTE ? {doff, 4'($urandom)} : 8'($urandom));
	endtask

	// kind, length byte, then the body: up to two bytes taken from body
	// (most significant first), longer bodies random
	task automatic push_option(input logic [7:0] kind, input logic [7:0] len,
			input logic [15:0] body, input int unsigned nbody);
		seg_bytes.push_back(kind);
		seg_bytes.push_back(len);
		for (int i = 0; i < nbody; i++)
			seg_bytes.push_back(nbody <= 2 ? body[8 * (nbody - 1 - i) +: 8] : 8'($urandom));
	endtask

	task automatic fill_to(input int unsigned n, input bit rand_fill, input logic [7:0] value);
		while (seg_bytes.size() < n)
			seg_bytes.push_back(rand_fill ? 8'($urandom) : value);
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// summary checker, oldest expectation first
	always @(posedge clk) begin : summary_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_summaries.size() == 0) begin
				$error("summary beat with none expected: %h", m_tdata);
				errors++;
			end else begin
				want = expected_summaries.pop_front();
				compare_field("status", want.status, m_tdata[2:0]);
				compare_field("hdr_len", want.hdr_len, m_tdata[8:3]);
				compare_field("mss", want.mss, m_tdata[24:9]);
				compare_field("mss_present", want.mss_present, m_tdata[25]);
				compare_field("wscale", want.wscale, m_tdata[33:26]);
				compare_field("wscale_present", want.wscale_present,
					m_tdata[34]);
				compare_field("sack_permitted", want.sack_permitted, m_tdata[35]);
				compare_field("nop_count", want.nop_count, m_tdata[41:36]);
				compare_field("pad_len", want.pad_len, m_tdata[47:42]);
			end
		end
	end

	// master side: random stall before each summary when stalls are on
	initial begin : summary_receiver
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_stalls ? $urandom_range(0, 14) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// watchdog: too long without a beat on either side
	always @(posedge clk)
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// bare 20-byte headers with all other bytes ones, then zeros
	task automatic test_header_extremes();
		seg_bytes.delete();
		for (int i = 0; i < MIN_HDR_BYTES; i++)
			seg_bytes.push_back(i == OFFSET_BYTE ? 8'h5F : 8'hFF);
		send_segment();
		seg_bytes.delete();
		for (int i = 0; i < MIN_HDR_BYTES; i++)
			seg_bytes.push_back(i == OFFSET_BYTE ? 8'h50 : 8'h00);
		send_segment();
	endtask

	// largest header carrying every known option, an unknown kind, END and padding
	task automatic test_full_options();
		begin_segment(4'd15);
		push_option(KIND_MSS, LEN_MSS, 16'hFFFF, 2);
		push_option(KIND_WS, LEN_WS, 16'd14, 1);
		push_option(KIND_SACK, LEN_SACK, 16'd0, 0);
		push_option(KIND_TS, LEN_TS, 16'd0, 8);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(8'hFF);
		seg_bytes.push_back(KIND_END);
		fill_to(63, 1'b1, 8'd0);
		send_segment();
	endtask

	// repeated mss (last wins), zero values, unknown kinds, no END
	task automatic test_option_values();
		begin_segment(4'd10);
		push_option(KIND_MSS, LEN_MSS, 16'h1234, 2);
		push_option(KIND_MSS, LEN_MSS, 16'h0000, 2);
		push_option(KIND_WS, LEN_WS, 16'hFF, 1);
		push_option(KIND_WS, LEN_WS, 16'h00, 1);
		seg_bytes.push_back(8'd5);
		seg_bytes.push_back(8'd6);
		seg_bytes.push_back(8'd7);
		seg_bytes.push_back(8'd9);
		fill_to(40, 1'b0, KIND_NOP);
		send_segment();
	endtask

	// forty nops fill the whole option area
	task automatic test_nop_run();
		begin_segment(4'd15);
		fill_to(60, 1'b0, KIND_NOP);
		send_segment();
	endtask

	// END at the start of the option area and on its last byte
	task automatic test_end_placement();
		begin_segment(4'd6);
		seg_bytes.push_back(KIND_END);
		fill_to(25, 1'b1, 8'd0);
		send_segment();
		begin_segment(4'd6);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(KIND_END);
		send_segment();
	endtask

	// one-byte segment and a header one byte short
	task automatic test_short_segments();
		seg_bytes.delete();
		seg_bytes.push_back(8'hFF);
		send_segment();
		begin_segment(4'd5);
		void'(seg_bytes.pop_back());
		send_segment();
	endtask

	// offsets 0 and 4, and a full-size offset on a bare header
	task automatic test_header_errors();
		begin_segment(4'd0);
		send_segment();
		begin_segment(4'd4);
		fill_to(24, 1'b1, 8'd0);
		send_segment();
		begin_segment(4'd15);
		send_segment();
	endtask

	// a wrong length byte for each checked kind
	task automatic test_bad_lengths();
		for (int k = 0; k < 4; k++) begin
			begin_segment(4'd7);
			seg_bytes.push_back(KIND_NOP);
			case (k)
				0:       push_option(KIND_MSS, 8'd5, 16'h1234, 2);
				1:       push_option(KIND_WS, LEN_SACK, 16'd7, 1);
				2:       push_option(KIND_SACK, LEN_WS, 16'd0, 0);
				default: push_option(KIND_TS, 8'd9, 16'd0, 8);
			endcase
			fill_to(28, 1'b0, KIND_NOP);
			fill_to(30, 1'b1, 8'd0);
			send_segment();
		end
	endtask

	// option crossing into the payload, and one cut off by the segment end
	task automatic test_overrun();
		begin_segment(4'd6);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(KIND_NOP);
		push_option(KIND_MSS, LEN_MSS, 16'hABCD, 2);
		send_segment();
		begin_segment(4'd6);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(KIND_NOP);
		seg_bytes.push_back(KIND_TS);
		send_segment();
	endtask

	// segment with a long payload, sent back to back
	task automatic test_long_segment();
		begin_segment(4'd8);
		push_option(KIND_MSS, LEN_MSS, 16'h5A5A, 2);
		fill_to(32, 1'b0, KIND_NOP);
		fill_to(LONG_SEGMENT, 1'b1, 8'd0);
		sender_gaps = 1'b0;
		send_segment();
		sender_gaps = 1'b1;
	endtask

	// mostly well-formed option areas with random content, some noise segments
	task automatic test_random_traffic();
		int unsigned bytes_sent, segments, area_end, room, sel, nbody, cut;
		logic [7:0]  kind, len;
		bytes_sent = 0;
		segments   = 0;
		while (bytes_sent < RANDOM_BYTES || segments < RANDOM_SEGMENTS) begin
			sender_gaps     = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 6) == 0) begin
				// raw noise: random length up to 70 bytes, any offset
				seg_bytes.delete();
				fill_to($urandom_range(1, 70), 1'b1, 8'd0);
			end else begin
				area_end = 4 * $urandom_range(MIN_DOFF, 15);
				begin_segment(4'(area_end / 4));
				while (seg_bytes.size() < area_end) begin
					room = area_end - seg_bytes.size();
					sel  = $urandom_range(0, 99);
					if (sel < 16) begin
						seg_bytes.push_back(KIND_NOP);
					end else if (sel < 62) begin
						if (sel < 30) begin
							kind = KIND_MSS;
							len  = LEN_MSS;
							nbody = VAL_MSS;
						end else if (sel < 42) begin
							kind = KIND_WS;
							len  = LEN_WS;
							nbody = VAL_WS;
						end else if (sel < 52) begin
							kind = KIND_SACK;
							len  = LEN_SACK;
							nbody = 0;
						end else begin
							kind = KIND_TS;
							len  = LEN_TS;
							nbody = SKIP_TS;
						end
						// now and then let an option run past the header
						if (2 + nbody <= room || $urandom_range(0, 5) == 0)
							push_option(kind, len, 16'($urandom), nbody);
						else
							seg_bytes.push_back(KIND_NOP);
					end else if (sel < 70) begin
						seg_bytes.push_back(KIND_END);
						fill_to(area_end, 1'b1, 8'd0);
					end else if (sel < 80) begin
						do kind = 8'($urandom_range(5, 255)); while (kind == KIND_TS);
						seg_bytes.push_back(kind);
					end else begin
						// checked kind with a random, mostly wrong, length byte
						case ($urandom_range(0, 3))
							0:       kind = KIND_MSS;
							1:       kind = KIND_WS;
							2:       kind = KIND_SACK;
							default: kind = KIND_TS;
						endcase
						push_option(kind, 8'($urandom), 16'd0, 0);
					end
				end
				if ($urandom_range(0, 9) == 0) begin
					// cut the segment short inside the header
					cut = $urandom_range(1, seg_bytes.size());
					while (seg_bytes.size() > cut) void'(seg_bytes.pop_back());
				end else begin
					fill_to(seg_bytes.size() + $urandom_range(0, 8), 1'b1, 8'd0);
				end
			end
			bytes_sent += seg_bytes.size();
			send_segment();
			segments++;
			if (segments == RANDOM_SEGMENTS / 2)
				wait_for_summaries();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_extremes();
		test_full_options();
		test_option_values();
		test_nop_run();
		test_end_placement();
		test_short_segments();
		test_header_errors();
		test_bad_lengths();
		test_overrun();
		test_long_segment();
		test_random_traffic();
		wait_for_summaries();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
